// File: rtl/core/adsr_pkg.sv
package adsr_pkg;

  localparam int unsigned LEVEL_FRAC_BITS = 23;
  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned FS_W = 18;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned STEP_W = FS_W + TIME_W;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
  localparam logic [FS_W-1:0] FS_RESET = FS_W'(48000);
  localparam logic [STEP_W-1:0] MS_PER_S = STEP_W'(1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

endpackage

// File: rtl/core/adsr_if.sv
interface adsr_req_if import adsr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [TIME_W-1:0]  attack_ms;
  logic [TIME_W-1:0]  decay_ms;
  logic [LEVEL_W-1:0] sustain_level;
  logic [TIME_W-1:0]  release_ms;

  modport source (output valid, cmd, attack_ms, decay_ms, sustain_level, release_ms,
                  input ready);
  modport sink (input valid, cmd, attack_ms, decay_ms, sustain_level, release_ms,
                output ready);
endinterface

interface adsr_rsp_if import adsr_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, level, phase, input ready);
  modport sink (input valid, level, phase, output ready);
endinterface

interface adsr_cfg_if import adsr_pkg::*;;
  logic            valid;
  logic            ready;
  logic [FS_W-1:0] sample_rate_hz;

  modport source (output valid, sample_rate_hz, input ready);
  modport sink (input valid, sample_rate_hz, output ready);
endinterface

// File: rtl/core/adsr_div.sv
module adsr_div import adsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] num_i,
  input  logic [STEP_W-1:0] den_i,
  output logic              done_o,
  output logic [STEP_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(STEP_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_W - 1);

  logic [STEP_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0] den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [STEP_W:0]   rem_sh;
  logic [STEP_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[STEP_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    rem_d   = ge ? rem_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
    quo_d   = {quo_q[STEP_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/core/adsr_envelope_generator_unit.sv
// Channel  Dir  Role    Payload
// req_i    in   sink    cmd, attack_ms, decay_ms, sustain_level, release_ms
// rsp_o    out  source  level, phase (one per sample tick)
// cfg_i    in   sink    sample_rate_hz
//
// A sample tick runs from accept through the fs*time multiply, 34 steps in
// the shared restoring divider, the divider done flag and one update; req_i
// is ready again in the cycle after the update.
// Note on, note off and unused commands complete in their accept cycle.
// rst_ni clears phase, level, start level and sets the sample rate to 48000.
// A pending result stalls the update cycle only; req_i waits while busy.
module adsr_envelope_generator_unit import adsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  adsr_req_if.sink   req_i,
  adsr_rsp_if.source rsp_o,
  adsr_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [FS_W-1:0]    fs_q;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [LEVEL_W-1:0] start_q, start_d;
  phase_e             phase_q, phase_d;

  logic [TIME_W-1:0]  att_q, dec_q, rel_q;
  logic [LEVEL_W-1:0] sus_q;
  logic [LEVEL_W-1:0] sus_clamp;
  logic [LEVEL_W-1:0] dist_q, dist_d;
  logic               den_zero_q;
  logic [TIME_W-1:0]  time_sel;
  logic [STEP_W-1:0]  den;
  logic [STEP_W-1:0]  num;

  logic               div_start;
  logic               div_done;
  logic [STEP_W-1:0]  quot;
  logic [STEP_W-1:0]  step;
  logic [STEP_W:0]    sum;
  logic [STEP_W-1:0]  lvl_ext;
  logic [STEP_W-1:0]  dec_val;

  logic               rsp_valid_q;
  logic [LEVEL_W-1:0] rsp_level_q;
  logic [PHASE_W-1:0] rsp_phase_q;

  logic               req_fire;
  logic               fin_go;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.level = rsp_level_q;
  assign rsp_o.phase = rsp_phase_q;
  assign fin_go      = (state_q == S_FIN) && (!rsp_valid_q || rsp_o.ready);
  assign div_start   = (state_q == S_LOAD);

  assign sus_clamp = (req_i.sustain_level > LEVEL_ONE) ? LEVEL_ONE : req_i.sustain_level;

  always_comb begin
    dist_d   = '0;
    time_sel = '0;
    case (phase_q)
      PH_ATTACK: begin
        dist_d   = LEVEL_ONE;
        time_sel = att_q;
      end
      PH_DECAY: begin
        dist_d   = (start_q > sus_q) ? start_q - sus_q : '0;
        time_sel = dec_q;
      end
      PH_RELEASE: begin
        dist_d   = start_q;
        time_sel = rel_q;
      end
      default: begin
        dist_d   = '0;
        time_sel = '0;
      end
    endcase
    den = STEP_W'(fs_q) * STEP_W'(time_sel);
    num = STEP_W'(dist_d) * MS_PER_S;
  end

  adsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    if (den_zero_q) begin
      step = STEP_W'(dist_q);
    end else if (quot == '0 && dist_q != '0) begin
      step = STEP_W'(1);
    end else begin
      step = quot;
    end
    lvl_ext = STEP_W'(level_q);
    sum     = {1'b0, lvl_ext} + {1'b0, step};
    dec_val = (lvl_ext > step) ? lvl_ext - step : '0;
  end

  always_comb begin
    level_d = level_q;
    start_d = start_q;
    phase_d = phase_q;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          case (cmd_e'(req_i.cmd))
            CMD_TICK: begin
              state_d = S_LOAD;
            end
            CMD_NOTE_ON: begin
              phase_d = PH_ATTACK;
              start_d = level_q;
            end
            CMD_NOTE_OFF: begin
              phase_d = PH_RELEASE;
              start_d = level_q;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LOAD: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
          case (phase_q)
            PH_ATTACK: begin
              if (sum >= (STEP_W + 1)'(LEVEL_ONE)) begin
                level_d = LEVEL_ONE;
                phase_d = PH_DECAY;
                start_d = LEVEL_ONE;
              end else begin
                level_d = sum[LEVEL_W-1:0];
              end
            end
            PH_DECAY: begin
              if (dec_val <= STEP_W'(sus_q)) begin
                level_d = sus_q;
                phase_d = PH_SUSTAIN;
                start_d = sus_q;
              end else begin
                level_d = dec_val[LEVEL_W-1:0];
              end
            end
            PH_SUSTAIN: begin
              level_d = sus_q;
            end
            PH_RELEASE: begin
              if (lvl_ext <= step) begin
                level_d = '0;
                phase_d = PH_OFF;
              end else begin
                level_d = dec_val[LEVEL_W-1:0];
              end
            end
            default: begin
              level_d = '0;
              phase_d = PH_OFF;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fs_q        <= FS_RESET;
      level_q     <= '0;
      start_q     <= '0;
      phase_q     <= PH_OFF;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      start_q <= start_d;
      phase_q <= phase_d;
      if (cfg_i.valid) begin
        fs_q <= cfg_i.sample_rate_hz;
      end
      if (fin_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      att_q <= req_i.attack_ms;
      dec_q <= req_i.decay_ms;
      rel_q <= req_i.release_ms;
      sus_q <= sus_clamp;
    end
    if (state_q == S_LOAD) begin
      dist_q     <= dist_d;
      den_zero_q <= (den == '0);
    end
    if (fin_go) begin
      rsp_level_q <= level_d;
      rsp_phase_q <= phase_d;
    end
  end

endmodule

// File: rtl/core/adsr_checker.sv
module adsr_checker import adsr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic [CMD_W-1:0]   req_cmd_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [LEVEL_W-1:0] rsp_level_i,
  input logic [PHASE_W-1:0] rsp_phase_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_level_i)
      && $stable(rsp_phase_i))
    else $error("result changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && req_cmd_i == CMD_TICK |=> !req_ready_i)
    else $error("request taken during sample computation");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_level_i <= LEVEL_ONE)
    else $error("level above full scale");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_phase_i <= PHASE_W'(PH_RELEASE))
    else $error("phase code out of range");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_phase_i == PHASE_W'(PH_OFF) |-> rsp_level_i == '0)
    else $error("nonzero level in off phase");

endmodule

bind adsr_envelope_generator_unit adsr_checker u_adsr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_cmd_i   (req_i.cmd),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_level_i (rsp_o.level),
  .rsp_phase_i (rsp_o.phase)
);
